@@ design/cfsr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfsr_pkg: shared types and constants of the framed sample receiver
// Frame parser states, phase and result codes, field widths and the
// byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfsr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_DATA_W  = 48;

    localparam logic [BYTE_W-1:0] MARK0_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] MARK1_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_DATA   = 8'h02;
    localparam logic [BYTE_W-1:0] TYPE_FINISH = 8'h04;

    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [WORD_W-1:0] REQUIRED_LEN_RESET = 16'd321;
    localparam logic [WORD_W-1:0] EPOCH_COUNT_RESET  = 16'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_LEN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_COUNT  = 1'b1;

    localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INFER   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PHASE   = 2'd3;

    typedef enum logic [3:0] {
        FS_MARK0,
        FS_MARK1,
        FS_TYPE,
        FS_SEQ0,
        FS_SEQ1,
        FS_LEN0,
        FS_LEN1,
        FS_DATA,
        FS_CRC0,
        FS_CRC1
    } frame_state_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_TRAIN,
        PH_VAL,
        PH_TEST
    } phase_t;

    function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[WORD_W-1] ? ({c[WORD_W-2:0], 1'b0} ^ CRC_POLY) : {c[WORD_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/crc_framed_sample_receiver.sv @@
// ----------------------------------------------------------------------------
// crc_framed_sample_receiver: framed sample receiver with CRC check
// Parses marker-framed byte streams, checks CRC-16/CCITT-FALSE, streams data
// payload bytes and returns ack verdicts and phase events.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel carries a command in s_tuser and a received
// byte in s_tdata. A byte request advances the frame parser and the CRC by one
// byte; an inference request advances the epoch and starts a phase; a restart
// request resets parser, sequence and epoch; the epoch count picks the phase.
// A request produces zero or one result on the m_ channel, whose kind travels
// in s_tuser's counterpart m_tuser.
// The result of a request is written to the output register in the cycle
// after the request is accepted. One request is accepted every cycle while
// the output register is empty or its result is taken; the rate is set by the
// single output register, which refills in the same cycle its result is taken.
// When the receiver holds m_tready low with a result pending, s_tready drops
// and the result stays stable until taken. Requests without a result never
// occupy the output register.
// After reset the parser hunts for the first marker, the phase is train and
// the registers hold a required payload length of 321 and an epoch count of 1.
// Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_sample_receiver
    import cfsr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  wire logic [CMD_W-1:0]       s_tuser,   // [1:0] cmd
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [7:0] payload_byte, [23:8] byte_index, [24] ack_status, [40:25] ack_seq,
    // [41] commit, [43:42] phase, [45:44] next_phase, [47:46] zero
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic [KIND_W-1:0]           m_tuser    // [1:0] kind
);

    frame_state_t      state_reg, state_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [WORD_W-1:0] seq_reg, seq_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;
    logic [WORD_W-1:0] crc_reg, crc_next;
    logic [WORD_W-1:0] exp_seq_reg, exp_seq_next;
    phase_t            mode_reg, mode_next;
    logic [WORD_W-1:0] epoch_reg, epoch_next;
    logic [WORD_W-1:0] required_len_reg;
    logic [WORD_W-1:0] epoch_count_reg;

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [KIND_W-1:0]      out_kind_reg;

    logic                   accept;
    logic                   res_valid;
    logic [KIND_W-1:0]      res_kind;
    logic [BYTE_W-1:0]      res_byte;
    logic [WORD_W-1:0]      res_index;
    logic                   res_status;
    logic [WORD_W-1:0]      res_seq;
    logic                   res_commit;
    phase_t                 res_phase;
    phase_t                 res_next_phase;

    logic [WORD_W-1:0] crc_upd;
    logic [WORD_W-1:0] len_full;
    logic [WORD_W-1:0] crc_rx_full;
    logic [WORD_W-1:0] count_inc;
    logic [WORD_W-1:0] epoch_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign crc_upd     = crc16_byte(crc_reg, s_tdata);
    assign len_full    = {s_tdata, len_reg[BYTE_W-1:0]};
    assign crc_rx_full = {s_tdata, crc_lo_reg};
    assign count_inc   = count_reg + 16'd1;
    assign epoch_inc   = (epoch_reg == '1) ? epoch_reg : epoch_reg + 16'd1;

    always_comb begin
        state_next     = state_reg;
        type_next      = type_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        crc_lo_next    = crc_lo_reg;
        crc_next       = crc_reg;
        exp_seq_next   = exp_seq_reg;
        mode_next      = mode_reg;
        epoch_next     = epoch_reg;
        res_valid      = 1'b0;
        res_kind       = KIND_PAYLOAD;
        res_byte       = '0;
        res_index      = '0;
        res_status     = 1'b0;
        res_seq        = '0;
        res_commit     = 1'b0;
        res_phase      = PH_TRAIN;
        res_next_phase = PH_TRAIN;

        case (s_tuser)
            CMD_BYTE: begin
                case (state_reg)
                    FS_MARK0: begin
                        state_next = (s_tdata == MARK0_BYTE) ? FS_MARK1 : FS_MARK0;
                    end
                    FS_MARK1: begin
                        if (s_tdata == MARK1_BYTE) begin
                            state_next = FS_TYPE;
                            crc_next   = CRC_INIT;
                        end else begin
                            state_next = FS_MARK0;
                        end
                    end
                    FS_TYPE: begin
                        type_next  = s_tdata;
                        crc_next   = crc_upd;
                        state_next = FS_SEQ0;
                    end
                    FS_SEQ0: begin
                        seq_next   = {8'h00, s_tdata};
                        crc_next   = crc_upd;
                        state_next = FS_SEQ1;
                    end
                    FS_SEQ1: begin
                        seq_next   = {s_tdata, seq_reg[BYTE_W-1:0]};
                        crc_next   = crc_upd;
                        state_next = FS_LEN0;
                    end
                    FS_LEN0: begin
                        len_next   = {8'h00, s_tdata};
                        crc_next   = crc_upd;
                        state_next = FS_LEN1;
                    end
                    FS_LEN1: begin
                        len_next   = len_full;
                        crc_next   = crc_upd;
                        count_next = '0;
                        if (len_full > required_len_reg) begin
                            state_next = FS_MARK0;
                        end else if (len_full == '0) begin
                            state_next = FS_CRC0;
                        end else begin
                            state_next = FS_DATA;
                        end
                    end
                    FS_DATA: begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (type_reg == TYPE_DATA) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_PAYLOAD;
                            res_byte  = s_tdata;
                            res_index = count_reg;
                        end
                        if (count_inc >= len_reg) begin
                            state_next = FS_CRC0;
                        end
                    end
                    FS_CRC0: begin
                        crc_lo_next = s_tdata;
                        state_next  = FS_CRC1;
                    end
                    FS_CRC1: begin
                        state_next = FS_MARK0;
                        res_seq    = seq_reg;
                        if (crc_reg != crc_rx_full) begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_ACK;
                            res_status = 1'b1;
                        end else if (type_reg == TYPE_FINISH) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_FINISH;
                            res_seq   = '0;
                            res_phase = mode_reg;
                            if (mode_reg == PH_TRAIN) begin
                                mode_next    = PH_VAL;
                                exp_seq_next = '0;
                            end
                            res_next_phase = mode_next;
                        end else if (type_reg == TYPE_DATA) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_ACK;
                            if (len_reg != required_len_reg) begin
                                res_status = 1'b1;
                            end else if (seq_reg == exp_seq_reg) begin
                                res_commit   = 1'b1;
                                exp_seq_next = exp_seq_reg + 16'd1;
                            end else if (seq_reg > exp_seq_reg) begin
                                res_status = 1'b1;
                            end
                        end else begin
                            res_seq = '0;
                        end
                    end
                    default: begin
                        state_next = FS_MARK0;
                    end
                endcase
            end
            CMD_INFER: begin
                epoch_next     = epoch_inc;
                mode_next      = (epoch_inc < epoch_count_reg) ? PH_TRAIN : PH_TEST;
                exp_seq_next   = '0;
                res_valid      = 1'b1;
                res_kind       = KIND_PHASE;
                res_phase      = mode_next;
                res_next_phase = mode_next;
            end
            CMD_RESTART: begin
                state_next   = FS_MARK0;
                crc_next     = CRC_INIT;
                count_next   = '0;
                exp_seq_next = '0;
                epoch_next   = '0;
                mode_next    = (epoch_count_reg == '0) ? PH_TEST : PH_TRAIN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FS_MARK0;
            crc_reg     <= CRC_INIT;
            count_reg   <= '0;
            exp_seq_reg <= '0;
            mode_reg    <= PH_TRAIN;
            epoch_reg   <= '0;
        end else if (accept) begin
            state_reg   <= state_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            exp_seq_reg <= exp_seq_next;
            mode_reg    <= mode_next;
            epoch_reg   <= epoch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            type_reg   <= type_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            required_len_reg <= REQUIRED_LEN_RESET;
            epoch_count_reg  <= EPOCH_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_REQUIRED_LEN: required_len_reg <= cfg_wdata;
                REG_EPOCH_COUNT:  epoch_count_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_kind_reg <= res_kind;
            out_data_reg <= {2'b00, res_next_phase, res_phase, res_commit, res_seq,
                             res_status, res_index, res_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

@@ design/cfsr_checker.sv @@
// ----------------------------------------------------------------------------
// cfsr_checker: port-level checks of the framed sample receiver
// Watches the request and result channels and the shape of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsr_checker
    import cfsr_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]     m_tuser
);

    // An empty output register always takes a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while no result is pending");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A new result only follows an accepted request.
    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted request");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[OUT_DATA_W-1:24] == '0)
        else $error("payload result carries verdict or phase fields");

    a_phase_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PHASE |->
            m_tdata[43:42] == m_tdata[45:44] && m_tdata[41:0] == '0)
        else $error("phase start result is malformed");

endmodule

bind crc_framed_sample_receiver cfsr_checker u_cfsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/crc_framed_sample_receiver_checker.sv @@
// ----------------------------------------------------------------------------
// crc_framed_sample_receiver_checker: reply predictor and scoreboard
// Watches the request, result and configuration ports of the framed sample
// receiver. It keeps its own frame parser, running CRC, sequence and phase
// state, queues the reply that each accepted request should cause, and
// compares every accepted result with the oldest queued reply field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_sample_receiver_checker
    import cfsr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_wdata,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  wire logic [CMD_W-1:0]       s_tuser,   // [1:0] cmd
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // [7:0] payload_byte, [23:8] byte_index, [24] ack_status, [40:25] ack_seq,
    // [41] commit, [43:42] phase, [45:44] next_phase, [47:46] zero
    input  wire logic [OUT_DATA_W-1:0]  m_tdata,
    input  wire logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
    output int                          fail_count,
    output int                          replies_pending
);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [WORD_W-1:0]  byte_index;
        logic               ack_status;
        logic [WORD_W-1:0]  ack_seq;
        logic               commit;
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] next_phase;
    } reply_t;

    reply_t replies_due[$];
    reply_t oldest;
    int     n_fail = 0;
    int     n_due  = 0;

    logic [WORD_W-1:0] r_req_len;
    logic [WORD_W-1:0] r_epochs;

    frame_state_t      p_state;
    logic [BYTE_W-1:0] p_type;
    logic [WORD_W-1:0] p_seq;
    logic [WORD_W-1:0] p_len;
    logic [WORD_W-1:0] p_count;
    logic [WORD_W-1:0] p_crc_rx;
    logic [WORD_W-1:0] p_crc;
    logic [WORD_W-1:0] p_eseq;
    phase_t            p_mode;
    logic [WORD_W-1:0] p_epoch;

    assign fail_count      = n_fail;
    assign replies_pending = n_due;

    // Bit-serial form of the CCITT update, MSB of the byte first.
    function automatic logic [WORD_W-1:0] crc_advance(input logic [WORD_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        logic              fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[WORD_W-1] ^ b[i];
            c  = {c[WORD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic clear_frame();
        p_state  = FS_MARK0;
        p_type   = '0;
        p_seq    = '0;
        p_len    = '0;
        p_count  = '0;
        p_crc_rx = '0;
        p_crc    = CRC_INIT;
    endtask

    task automatic queue_ack(input logic status, input logic [WORD_W-1:0] seq,
                             input logic commit);
        reply_t r;
        r            = '0;
        r.kind       = KIND_ACK;
        r.ack_status = status;
        r.ack_seq    = seq;
        r.commit     = commit;
        replies_due.push_back(r);
    endtask

    task automatic close_frame();
        reply_t r;
        r = '0;
        if (p_crc != p_crc_rx) begin
            queue_ack(1'b1, p_seq, 1'b0);
        end else if (p_type == TYPE_FINISH) begin
            r.kind  = KIND_FINISH;
            r.phase = p_mode;
            if (p_mode == PH_TRAIN) begin
                p_mode = PH_VAL;
                p_eseq = '0;
            end
            r.next_phase = p_mode;
            replies_due.push_back(r);
        end else if (p_type == TYPE_DATA) begin
            if (p_len != r_req_len) begin
                queue_ack(1'b1, p_seq, 1'b0);
            end else if (p_seq == p_eseq) begin
                queue_ack(1'b0, p_seq, 1'b1);
                p_eseq = p_eseq + 16'd1;
            end else if (p_seq < p_eseq) begin
                queue_ack(1'b0, p_seq, 1'b0);
            end else begin
                queue_ack(1'b1, p_seq, 1'b0);
            end
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        reply_t r;
        r = '0;
        case (p_state)
            FS_MARK0: begin
                p_state = (b == MARK0_BYTE) ? FS_MARK1 : FS_MARK0;
            end
            FS_MARK1: begin
                if (b == MARK1_BYTE) begin
                    p_state = FS_TYPE;
                    p_crc   = CRC_INIT;
                end else begin
                    p_state = FS_MARK0;
                end
            end
            FS_TYPE: begin
                p_type  = b;
                p_crc   = crc_advance(p_crc, b);
                p_state = FS_SEQ0;
            end
            FS_SEQ0: begin
                p_seq   = {8'h00, b};
                p_crc   = crc_advance(p_crc, b);
                p_state = FS_SEQ1;
            end
            FS_SEQ1: begin
                p_seq   = {b, p_seq[7:0]};
                p_crc   = crc_advance(p_crc, b);
                p_state = FS_LEN0;
            end
            FS_LEN0: begin
                p_len   = {8'h00, b};
                p_crc   = crc_advance(p_crc, b);
                p_state = FS_LEN1;
            end
            FS_LEN1: begin
                p_len   = {b, p_len[7:0]};
                p_crc   = crc_advance(p_crc, b);
                p_count = '0;
                if (p_len > r_req_len) begin
                    p_state = FS_MARK0;
                end else begin
                    p_state = (p_len == '0) ? FS_CRC0 : FS_DATA;
                end
            end
            FS_DATA: begin
                p_crc = crc_advance(p_crc, b);
                if (p_type == TYPE_DATA) begin
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = p_count;
                    replies_due.push_back(r);
                end
                p_count = p_count + 16'd1;
                if (p_count >= p_len) begin
                    p_state = FS_CRC0;
                end
            end
            FS_CRC0: begin
                p_crc_rx = {8'h00, b};
                p_state  = FS_CRC1;
            end
            FS_CRC1: begin
                p_crc_rx = {b, p_crc_rx[7:0]};
                close_frame();
                p_state = FS_MARK0;
            end
            default: begin
                p_state = FS_MARK0;
            end
        endcase
    endtask

    task automatic receiver_step(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
        reply_t r;
        r = '0;
        case (cmd)
            CMD_BYTE: begin
                parse_byte(b);
            end
            CMD_INFER: begin
                if (p_epoch != 16'hFFFF) begin
                    p_epoch = p_epoch + 16'd1;
                end
                p_mode       = (p_epoch < r_epochs) ? PH_TRAIN : PH_TEST;
                p_eseq       = '0;
                r.kind       = KIND_PHASE;
                r.phase      = p_mode;
                r.next_phase = p_mode;
                replies_due.push_back(r);
            end
            CMD_RESTART: begin
                clear_frame();
                p_eseq  = '0;
                p_epoch = '0;
                p_mode  = (r_epochs == '0) ? PH_TEST : PH_TRAIN;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            r_req_len = REQUIRED_LEN_RESET;
            r_epochs  = EPOCH_COUNT_RESET;
            clear_frame();
            p_eseq  = '0;
            p_mode  = PH_TRAIN;
            p_epoch = '0;
            replies_due.delete();
            n_due <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result of kind %0d with no reply pending", m_tuser);
                    n_fail++;
                end else begin
                    oldest = replies_due.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(m_tuser));
                    check_field("payload_byte", 32'(oldest.payload_byte),
                                32'(m_tdata[7:0]));
                    check_field("byte_index", 32'(oldest.byte_index),
                                32'(m_tdata[23:8]));
                    check_field("ack_status", 32'(oldest.ack_status), 32'(m_tdata[24]));
                    check_field("ack_seq", 32'(oldest.ack_seq), 32'(m_tdata[40:25]));
                    check_field("commit", 32'(oldest.commit), 32'(m_tdata[41]));
                    check_field("phase", 32'(oldest.phase), 32'(m_tdata[43:42]));
                    check_field("next_phase", 32'(oldest.next_phase),
                                32'(m_tdata[45:44]));
                    check_field("padding", 32'd0, 32'(m_tdata[47:46]));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_REQUIRED_LEN: r_req_len = cfg_wdata;
                    REG_EPOCH_COUNT:  r_epochs  = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                receiver_step(s_tuser, s_tdata);
            end
            n_due <= replies_due.size();
        end
    end

endmodule

`default_nettype wire

@@ dv/crc_framed_sample_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// crc_framed_sample_receiver_tb: stimulus and verdict for the sample receiver
// Drives byte, inference, restart and unused requests: a directed pass over
// the frame cases, then random frames, line noise and broken frames under
// several settings and idle patterns. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_sample_receiver_tb;
    import cfsr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam int               WATCHDOG_LIMIT = 5000;
    localparam int               PHASE_ITEMS    = 340;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic [CMD_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]      m_tuser;

    int fail_count;
    int replies_pending;

    int                send_idle  = 0;
    int                recv_stall = 0;
    int                quiet      = 0;
    int                items_sent = 0;
    logic [WORD_W-1:0] cur_len    = REQUIRED_LEN_RESET;
    logic [WORD_W-1:0] next_seq   = '0;

    crc_framed_sample_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    crc_framed_sample_receiver_checker i_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .replies_pending (replies_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", quiet);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [WORD_W-1:0] crc_ccitt_add(input logic [WORD_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        repeat (BYTE_W) begin
            if (c[WORD_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_covered(inout logic [WORD_W-1:0] crc, input logic [BYTE_W-1:0] b);
        crc = crc_ccitt_add(crc, b);
        send_req(CMD_BYTE, b);
    endtask

    // A cut of zero or more stops after that many payload bytes, without CRC.
    task automatic send_packet(input logic [BYTE_W-1:0] ftype, input logic [WORD_W-1:0] seq,
                               input logic [WORD_W-1:0] len, input bit bad_crc, input int cut);
        logic [WORD_W-1:0] crc;
        int                n;
        crc = CRC_INIT;
        n   = (cut >= 0) ? cut : int'(len);
        send_req(CMD_BYTE, MARK0_BYTE);
        send_req(CMD_BYTE, MARK1_BYTE);
        send_covered(crc, ftype);
        send_covered(crc, seq[7:0]);
        send_covered(crc, seq[15:8]);
        send_covered(crc, len[7:0]);
        send_covered(crc, len[15:8]);
        for (int i = 0; i < n; i++) begin
            send_covered(crc, 8'($urandom));
        end
        if (cut < 0) begin
            if (bad_crc) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end
            send_req(CMD_BYTE, crc[7:0]);
            send_req(CMD_BYTE, crc[15:8]);
            if (!bad_crc && ftype == TYPE_DATA && len == cur_len && seq == next_seq) begin
                next_seq = next_seq + 16'd1;
            end else if (!bad_crc && ftype == TYPE_FINISH) begin
                next_seq = '0;
            end
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] epochs);
        wait_drain();
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REQUIRED_LEN;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_index <= REG_EPOCH_COUNT;
        cfg_wdata <= epochs;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_len = len;
    endtask

    task automatic random_frame();
        logic [BYTE_W-1:0] ftype;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] len;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            ftype = TYPE_DATA;
        end else if (pick < 88) begin
            ftype = TYPE_FINISH;
        end else begin
            ftype = 8'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
            seq = next_seq;
        end else if (pick < 80) begin
            seq = next_seq - 16'($urandom_range(1, 3));
        end else if (pick < 90) begin
            seq = next_seq + 16'($urandom_range(1, 3));
        end else begin
            seq = 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            len = cur_len;
        end else if (pick < 88) begin
            len = 16'($urandom_range(0, cur_len));
        end else if (pick < 96) begin
            len = cur_len + 16'($urandom_range(1, 3));
        end else begin
            len = 16'($urandom_range(0, 20));
        end
        send_packet(ftype, seq, len, ($urandom_range(99) < 12), -1);
    endtask

    task automatic line_noise();
        logic [BYTE_W-1:0] b;
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(99) < 20) begin
                send_req(CMD_BYTE, MARK0_BYTE);
                b = 8'($urandom);
                if (b == MARK1_BYTE) begin
                    b = ~b;
                end
                send_req(CMD_BYTE, b);
            end else begin
                send_req(CMD_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic random_phase(input int idle, input int stall);
        int pick;
        int phase_end;
        send_idle  = idle;
        recv_stall = stall;
        phase_end  = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                random_frame();
            end else if (pick < 84) begin
                line_noise();
            end else if (pick < 92) begin
                send_req(CMD_INFER, 8'($urandom));
                next_seq = '0;
            end else if (pick < 95) begin
                send_req(CMD_RESTART, 8'($urandom));
                next_seq = '0;
            end else if (pick < 97) begin
                send_req(CMD_UNUSED, 8'($urandom));
            end else begin
                send_packet(TYPE_DATA, next_seq, cur_len, 1'b0,
                            $urandom_range(0, cur_len - 1));
                send_req(CMD_RESTART, 8'($urandom));
                next_seq = '0;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frame cases with a two-byte payload and one epoch.
        set_config(16'd2, 16'd1);
        send_req(CMD_BYTE, 8'h00);
        send_req(CMD_BYTE, MARK0_BYTE);
        send_req(CMD_BYTE, 8'h13);
        send_req(CMD_BYTE, 8'hFF);
        send_packet(TYPE_DATA, 16'd0, 16'd2, 1'b0, -1);
        send_packet(TYPE_DATA, 16'd0, 16'd2, 1'b0, -1);
        send_packet(TYPE_DATA, 16'hFFFF, 16'd2, 1'b0, -1);
        send_packet(TYPE_DATA, 16'd1, 16'd2, 1'b1, -1);
        send_packet(TYPE_DATA, 16'd1, 16'd1, 1'b0, -1);
        send_packet(TYPE_DATA, 16'd1, 16'd0, 1'b0, -1);
        send_packet(TYPE_DATA, 16'd1, 16'd3, 1'b0, -1);
        send_packet(8'h07, 16'd1, 16'd2, 1'b0, -1);
        send_packet(TYPE_FINISH, 16'd0, 16'd0, 1'b0, -1);
        send_packet(TYPE_FINISH, 16'd0, 16'd0, 1'b0, -1);
        send_req(CMD_INFER, 8'h00);
        send_req(CMD_UNUSED, 8'hFF);
        send_req(CMD_RESTART, 8'h00);

        // Widest length and no training epochs: restart lands in the test phase.
        set_config(16'hFFFF, 16'h0000);
        send_req(CMD_RESTART, 8'hFF);
        send_packet(TYPE_DATA, 16'd0, 16'hFFFF, 1'b0, 3);
        send_req(CMD_RESTART, 8'h00);
        send_packet(TYPE_DATA, 16'd0, 16'd5, 1'b0, -1);
        send_req(CMD_INFER, 8'hFF);
        send_packet(TYPE_FINISH, 16'd0, 16'd0, 1'b0, -1);

        next_seq = '0;
        set_config(16'd1, 16'd0);
        send_req(CMD_RESTART, 8'h00);
        random_phase(0, 0);
        set_config(16'($urandom_range(2, 8)), 16'd3);
        random_phase(47, 0);
        set_config(16'($urandom_range(2, 8)), 16'd1);
        random_phase(0, 47);
        set_config(16'($urandom_range(9, 24)), 16'($urandom_range(2, 5)));
        random_phase(27, 27);

        wait_drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && replies_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
